FILE: rtl/core/vector_heading_degrees_defines.svh
// ----------------------------------------------------------------------------
// vector_heading_degrees_defines.svh
// assertion macros shared by the heading block
// ----------------------------------------------------------------------------
`ifndef VECTOR_HEADING_DEGREES_DEFINES_SVH
`define VECTOR_HEADING_DEGREES_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define VHD_ASSERT_IMP(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define VHD_ASSERT_NXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error(msg);

`endif

FILE: rtl/core/vhd_pkg.sv
// ----------------------------------------------------------------------------
// vhd_pkg
// widths, constants and the arctangent table of the heading pipeline
// ----------------------------------------------------------------------------
package vhd_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int PRESCALE     = 24;
  localparam int FRAC_BITS    = 16;
  localparam int FRAC_ONE     = 1 << FRAC_BITS;
  localparam int FULL_TURN    = 360;
  localparam int HDG_W        = 9;

  // rotated vector: coordinate difference, one bit for negation, prescale, gain
  localparam int XY_W = COORD_BITS + 2 + PRESCALE + 3;
  // angle accumulator, degrees with 16 fraction bits, up to about 190 degrees
  localparam int Z_W  = 26;
  localparam int D_W  = Z_W + 1;
  localparam int Q_W  = D_W - FRAC_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic signed [COORD_BITS+1:0] rot_t;
  typedef logic signed [XY_W-1:0]       xy_t;
  typedef logic signed [Z_W-1:0]        z_t;
  typedef logic signed [D_W-1:0]        d_t;
  typedef logic signed [Q_W-1:0]        q_t;
  typedef logic        [HDG_W-1:0]      heading_t;

  localparam z_t Q90 = z_t'(90 * FRAC_ONE);

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
  function automatic z_t atan_q16(input int unsigned i);
    z_t r;
    case (i)
      0:       r = z_t'(2949120);
      1:       r = z_t'(1740967);
      2:       r = z_t'(919879);
      3:       r = z_t'(466945);
      4:       r = z_t'(234379);
      5:       r = z_t'(117304);
      6:       r = z_t'(58666);
      7:       r = z_t'(29335);
      8:       r = z_t'(14668);
      9:       r = z_t'(7334);
      10:      r = z_t'(3667);
      11:      r = z_t'(1833);
      12:      r = z_t'(917);
      13:      r = z_t'(458);
      14:      r = z_t'(229);
      15:      r = z_t'(115);
      16:      r = z_t'(57);
      17:      r = z_t'(29);
      18:      r = z_t'(14);
      19:      r = z_t'(7);
      20:      r = z_t'(4);
      21:      r = z_t'(2);
      22:      r = z_t'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/vhd_pts_if.sv
// ----------------------------------------------------------------------------
// vhd_pts_if
// point pair channel: start and end point of one vector
// ----------------------------------------------------------------------------
interface vhd_pts_if;
  logic           valid;
  logic           ready;
  vhd_pkg::coord_t start_x;
  vhd_pkg::coord_t start_y;
  vhd_pkg::coord_t end_x;
  vhd_pkg::coord_t end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

FILE: rtl/core/vhd_hdg_if.sv
// ----------------------------------------------------------------------------
// vhd_hdg_if
// heading channel: compass heading in whole degrees
// ----------------------------------------------------------------------------
interface vhd_hdg_if;
  logic              valid;
  logic              ready;
  vhd_pkg::heading_t heading;

  modport source (output valid, heading, input ready);
  modport sink   (input valid, heading, output ready);
endinterface

FILE: rtl/core/vector_heading_degrees.sv
// ----------------------------------------------------------------------------
// vector_heading_degrees: compass heading of a vector by pipelined cordic
// throughput: one word per cycle unless the output stalls;
// each cordic stage does one micro-rotation
// reset: synchronous, clears only the valid bits, no clearing pass
// ----------------------------------------------------------------------------
`include "vector_heading_degrees_defines.svh"

module vector_heading_degrees (
  input  logic     clk,
  input  logic     rst,
  vhd_pts_if.sink   points,
  vhd_hdg_if.source result
);

  localparam int S = vhd_pkg::STEPS;

  // stage 0 holds the pre-rotated, prescaled vector; stage k holds it after
  // k micro-rotations; the output register holds the finished heading
  logic          v [0:S];
  vhd_pkg::xy_t  x [0:S];
  vhd_pkg::xy_t  y [0:S];
  vhd_pkg::z_t   z [0:S];

  vhd_pkg::xy_t  x_next [1:S];
  vhd_pkg::xy_t  y_next [1:S];
  vhd_pkg::z_t   z_next [1:S];

  // per-stage advance: a stage takes a new word when it is empty or its
  // contents move on, so bubbles close up behind a stalled output
  logic          adv [0:S+1];

  logic              out_valid;
  vhd_pkg::heading_t out_heading;

  // stage 0 working values
  vhd_pkg::diff_t num;
  vhd_pkg::diff_t den;
  vhd_pkg::rot_t  xr;
  vhd_pkg::rot_t  yr;
  vhd_pkg::z_t    z0;

  // output stage working values
  vhd_pkg::d_t       d;
  vhd_pkg::d_t       d_mag;
  vhd_pkg::q_t       q;
  vhd_pkg::q_t       q_wrap;
  vhd_pkg::heading_t heading_next;

  // advance chain, from the output back to the input
  always_comb begin
    adv[S+1] = !out_valid || result.ready;
    for (int k = S; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign points.ready  = adv[0];
  assign result.valid  = out_valid;
  assign result.heading = out_heading;

  // differences and quadrant pre-rotation by plus or minus 90 degrees
  always_comb begin
    num = vhd_pkg::diff_t'(points.start_y) - vhd_pkg::diff_t'(points.end_y);
    den = vhd_pkg::diff_t'(points.end_x) - vhd_pkg::diff_t'(points.start_x);
    if (den[vhd_pkg::COORD_BITS]) begin
      if (!num[vhd_pkg::COORD_BITS]) begin
        xr = vhd_pkg::rot_t'(num);
        yr = -vhd_pkg::rot_t'(den);
        z0 = vhd_pkg::Q90;
      end else begin
        xr = -vhd_pkg::rot_t'(num);
        yr = vhd_pkg::rot_t'(den);
        z0 = -vhd_pkg::Q90;
      end
    end else begin
      xr = vhd_pkg::rot_t'(den);
      yr = vhd_pkg::rot_t'(num);
      z0 = '0;
    end
  end

  // one micro-rotation per stage, shift fixed by the stage position
  always_comb begin
    for (int k = 1; k <= S; k++) begin
      if (y[k-1][vhd_pkg::XY_W-1]) begin
        x_next[k] = x[k-1] - (y[k-1] >>> (k-1));
        y_next[k] = y[k-1] + (x[k-1] >>> (k-1));
        z_next[k] = z[k-1] - vhd_pkg::atan_q16(k-1);
      end else if (y[k-1] != '0) begin
        x_next[k] = x[k-1] + (y[k-1] >>> (k-1));
        y_next[k] = y[k-1] - (x[k-1] >>> (k-1));
        z_next[k] = z[k-1] + vhd_pkg::atan_q16(k-1);
      end else begin
        // vector already on the axis: angle stays put
        x_next[k] = x[k-1];
        y_next[k] = y[k-1];
        z_next[k] = z[k-1];
      end
    end
  end

  // 90 minus the angle, truncated toward zero, wrapped into 0..359
  always_comb begin
    d = vhd_pkg::d_t'(vhd_pkg::Q90) - vhd_pkg::d_t'(z[S]);
    if (d[vhd_pkg::D_W-1]) begin
      d_mag = -d;
      q     = -vhd_pkg::q_t'(d_mag >>> vhd_pkg::FRAC_BITS);
    end else begin
      d_mag = d;
      q     = vhd_pkg::q_t'(d_mag >>> vhd_pkg::FRAC_BITS);
    end
    if (q[vhd_pkg::Q_W-1]) begin
      q_wrap = q + vhd_pkg::q_t'(vhd_pkg::FULL_TURN);
    end else begin
      q_wrap = q;
    end
    heading_next = q_wrap[vhd_pkg::HDG_W-1:0];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= S; k++) begin
        v[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      if (adv[0]) begin
        v[0] <= points.valid;
      end
      for (int k = 1; k <= S; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (adv[S+1]) begin
        out_valid <= v[S];
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x[0] <= vhd_pkg::xy_t'(xr) <<< vhd_pkg::PRESCALE;
      y[0] <= vhd_pkg::xy_t'(yr) <<< vhd_pkg::PRESCALE;
      z[0] <= z0;
    end
    for (int k = 1; k <= S; k++) begin
      if (adv[k]) begin
        x[k] <= x_next[k];
        y[k] <= y_next[k];
        z[k] <= z_next[k];
      end
    end
    if (adv[S+1]) begin
      out_heading <= heading_next;
    end
  end

  // a delivered heading always lies on the compass
  `VHD_ASSERT_IMP(a_heading_range, out_valid, out_heading < vhd_pkg::heading_t'(vhd_pkg::FULL_TURN), "heading out of range")
  // input only backs up when the whole pipe is held by the output
  `VHD_ASSERT_IMP(a_backpressure, !points.ready, out_valid && !result.ready, "input stalled without output stall")
  // a word leaving the last cordic stage lands in the output register
  `VHD_ASSERT_NXT(a_last_stage, v[S] && adv[S+1], out_valid, "word lost after last stage")

endmodule

FILE: tb/heading_checker.sv
// ----------------------------------------------------------------------------
// heading_checker
// watches both channels, works out the heading of every accepted point pair
// and compares it with the word that comes out of the heading channel
// ----------------------------------------------------------------------------
module heading_checker
  import vhd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  vhd_pts_if        pts,
  vhd_hdg_if        hdg,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam longint ATAN_DEG [TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  heading_t heading_queue [$];
  heading_t want;

  // cordic vectoring of (den, num), then 90 minus the angle in whole degrees
  function automatic heading_t compass_heading(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    longint x, y, z, t, xs, ys, d, q;
    int     i;
    y = longint'(sy) - longint'(ey);
    x = longint'(ex) - longint'(sx);
    z = 0;
    // left half plane: quarter turn first
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * FRAC_ONE;
      end else begin
        t = x; x = -y; y = t; z = -90 * FRAC_ONE;
      end
    end
    x = x * (longint'(1) <<< PRESCALE);
    y = y * (longint'(1) <<< PRESCALE);
    for (i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_DEG[i];
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_DEG[i];
      end
    end
    d = longint'(90 * FRAC_ONE) - z;
    q = d / FRAC_ONE;
    q = q % FULL_TURN;
    if (q < 0) q = q + FULL_TURN;
    return heading_t'(q);
  endfunction

  task automatic report_mismatch(string what, heading_t got, heading_t exp_hdg);
    $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, exp_hdg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      pending    <= 0;
    end else begin
      if (pts.valid && pts.ready)
        heading_queue.push_back(compass_heading(pts.start_x, pts.start_y,
                                                pts.end_x, pts.end_y));
      if (hdg.valid && hdg.ready) begin
        if (heading_queue.size() == 0) begin
          report_mismatch("heading word with none expected", hdg.heading, '0);
        end else begin
          want = heading_queue.pop_front();
          if (hdg.heading !== want)
            report_mismatch("heading", hdg.heading, want);
        end
      end
      pending <= heading_queue.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives point pairs into the heading block with random gaps on both sides,
// a checker beside the block predicts and compares every heading word
// ----------------------------------------------------------------------------
module testbench;
  import vhd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 60;
  // several times the slowest legal run
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  // no idling on either side while this is set
  logic calm = 1'b0;

  int          fails;
  int          pending;
  int unsigned cycle_count;

  vhd_pts_if points ();
  vhd_hdg_if result ();

  vector_heading_degrees dut (
    .clk    (clk),
    .rst    (rst),
    .points (points),
    .result (result)
  );

  heading_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .pts        (points),
    .hdg        (result),
    .fail_count (fails),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // watchdog: a cycle counter that ends a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL vector_heading_degrees");
    $finish;
  end

  // heading sink: holds off about 15 percent of the time, never while calm
  initial begin
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst)
        result.ready <= 1'b0;
      else
        result.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // offers one point pair and waits for the block to take it; called just
  // after a rising edge, returns just after the edge that took the word
  task automatic send_points(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    if (!calm && $urandom_range(99) < 15) begin
      // idle, valid low, with rubbish on the payload
      points.valid   <= 1'b0;
      points.start_x <= coord_t'($urandom());
      points.start_y <= coord_t'($urandom());
      points.end_x   <= coord_t'($urandom());
      points.end_y   <= coord_t'($urandom());
      @(posedge clk);
    end
    points.valid   <= 1'b1;
    points.start_x <= sx;
    points.start_y <= sy;
    points.end_x   <= ex;
    points.end_y   <= ey;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
  endtask

  // one of a few values at the edges of the coordinate range
  function automatic coord_t edge_value();
    case ($urandom_range(4))
      0:       return coord_t'(-32768);
      1:       return coord_t'(-1);
      2:       return coord_t'(0);
      3:       return coord_t'(1);
      default: return coord_t'(32767);
    endcase
  endfunction

  initial begin
    coord_t sx, sy, ex, ey;
    int     dx, dy, span, n;

    points.valid   = 1'b0;
    points.start_x = '0;
    points.start_y = '0;
    points.end_x   = '0;
    points.end_y   = '0;

    // hold the synchronous reset, then release it
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // equal points give due east
    send_points(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_points(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_points(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    // the four compass points, screen y grows downward
    send_points(16'sd0, 16'sd0, 16'sd0, -16'sd100);
    send_points(16'sd0, 16'sd0, 16'sd100, 16'sd0);
    send_points(16'sd0, 16'sd0, 16'sd0, 16'sd100);
    send_points(16'sd0, 16'sd0, -16'sd100, 16'sd0);
    // diagonals, one per quadrant
    send_points(16'sd10, 16'sd10, 16'sd20, 16'sd0);
    send_points(16'sd10, 16'sd10, 16'sd20, 16'sd20);
    send_points(16'sd10, 16'sd10, 16'sd0, 16'sd20);
    send_points(16'sd10, 16'sd10, 16'sd0, 16'sd0);
    // widest spans along both axes and one diagonal
    send_points(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_points(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_points(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767);
    send_points(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
    send_points(16'sd0, 16'sd32767, 16'sd0, -16'sd32768);
    send_points(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
    // shallow angles on either side of the west and east axes
    send_points(16'sd32767, 16'sd0, -16'sd32768, 16'sd1);
    send_points(16'sd32767, 16'sd0, -16'sd32768, -16'sd1);
    send_points(-16'sd32768, 16'sd0, 16'sd32767, 16'sd1);
    send_points(-16'sd32768, 16'sd0, 16'sd32767, -16'sd1);
    // unit steps off the axes
    send_points(16'sd0, 16'sd0, 16'sd1, -16'sd1);
    send_points(16'sd0, 16'sd0, -16'sd1, 16'sd1);

    // ---- random part ----
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 300) && (n < 500);
      sx = coord_t'($urandom());
      sy = coord_t'($urandom());
      ex = coord_t'($urandom());
      ey = coord_t'($urandom());
      case ($urandom_range(9))
        0, 1, 2, 3: ;                       // full range on all four fields
        4, 5: begin                         // short vectors, angles coarse
          dx = int'($urandom_range(30)) - 15;
          dy = int'($urandom_range(30)) - 15;
          ex = coord_t'(int'(sx) + dx);
          ey = coord_t'(int'(sy) + dy);
        end
        6: begin                            // on an axis
          if ($urandom_range(1)) ex = sx;
          else                   ey = sy;
        end
        7: begin                            // on a diagonal, no wrap
          sx   = coord_t'(int'($urandom_range(32000)) - 16000);
          sy   = coord_t'(int'($urandom_range(32000)) - 16000);
          span = int'($urandom_range(16000));
          ex   = coord_t'($urandom_range(1) ? int'(sx) + span : int'(sx) - span);
          ey   = coord_t'($urandom_range(1) ? int'(sy) + span : int'(sy) - span);
        end
        8: begin                            // equal points
          ex = sx;
          ey = sy;
        end
        default: begin                      // range edges
          sx = edge_value();
          sy = edge_value();
          ex = edge_value();
          ey = edge_value();
        end
      endcase
      send_points(sx, sy, ex, ey);
    end

    points.valid <= 1'b0;
    calm         <= 1'b0;
    @(posedge clk);

    // drain, then a margin to catch any stray heading word
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("PASS vector_heading_degrees");
    end else begin
      $display("FAIL vector_heading_degrees");
    end
    $finish;
  end

endmodule
